// ===== hdl/prm_pkg.sv =====
`timescale 1ns / 1ps
package prm_pkg;

	localparam int unsigned IN_DATA_W  = 160;
	localparam int unsigned OUT_DATA_W = 328;
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned DIV_CNT_W  = 7;

	localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 7'd64;

	localparam logic [31:0] SEQ_MAGIC     = 32'hC0DE_0000;
	localparam logic [31:0] SEQ_HIGH_MASK = 32'hFFFF_0000;
	localparam logic [31:0] US_PER_MS     = 32'd1000;
	localparam logic [7:0]  ID_RESET      = 8'd1;

	// floor(x / 1000) = (x * MS_RECIP) >> 38 and floor(x / 5) = (x * EW_RECIP) >> 34
	// for every 32-bit x
	localparam logic [31:0] MS_RECIP = 32'h1062_4DD3;
	localparam logic [31:0] EW_RECIP = 32'hCCCC_CCCD;

	localparam logic [CFG_IDX_W-1:0] REG_OWN_SYSTEM    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_COMPONENT = 8'd1;

	localparam logic [KIND_W-1:0] KIND_PROBE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ECHO    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_PING = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MS,
		ST_EW,
		ST_MEAN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic     load_in;
		logic     eval;
		logic     div_start;
		logic     upd_ms;
		logic     upd_ewma;
		logic     upd_mean;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic is_sample;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

// ===== hdl/ping_rtt_probe_monitor.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Handshake              Payload
// s_       in   s_tvalid / s_tready    s_tdata (160 b), s_tuser = operation
// m_       out  m_tvalid / m_tready    m_tdata (328 b), m_tuser = kind
// cfg_     in   cfg_valid / cfg_ready  cfg_index (8 b), cfg_data (8 b)
//
// One item at a time. Ticks, echoes and ignored pings go from evaluation straight to
// the output state. A round-trip sample scales ms and smoothing by reciprocal multiply
// and runs a 64-step divider for the mean before it reaches the output state.
// A result held by m_tready stalls the block in its output state.
// Reset loads own ids with 1 and clears all counters; least ms reads all ones.
module ping_rtt_probe_monitor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// now_us[31:0], in_time_usec[95:32], in_seq[127:96], in_target_system,
	// in_target_component, sender_system, sender_component
	input  logic [prm_pkg::IN_DATA_W-1:0]     s_tdata,
	// operation
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// out_time_usec, out_seq, out_target_system, out_target_component, rtt_us,
	// ewma_us, one_way_us, min_ms, max_ms, mean_us, timeout_count, zero pad
	output logic [prm_pkg::OUT_DATA_W-1:0]    m_tdata,
	// kind
	output logic [prm_pkg::KIND_W-1:0]        m_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [prm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [7:0]                        cfg_data
);

	prm_pkg::cmd_t  cmd;
	prm_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	prm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	prm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// ===== hdl/prm_div.sv =====
`timescale 1ns / 1ps
module prm_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [63:0]                    dividend,
	input  logic [prm_pkg::DIV_CNT_W-1:0]  nbits,
	input  logic [31:0]                    divisor,
	output logic [63:0]                    quo,
	output logic                           done
);

	logic [63:0]                   q_q;
	logic [31:0]                   rem_q;
	logic [31:0]                   dvs_q;
	logic [prm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [32:0]                   trial;
	logic                          fits;
	logic [32:0]                   diff;

	assign trial = {rem_q, q_q[63]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 7'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			q_q   <= {q_q[62:0], fits};
			rem_q <= fits ? diff[31:0] : trial[31:0];
		end
	end

	assign quo  = q_q;
	assign done = done_q;

endmodule

// ===== hdl/prm_ctrl.sv =====
`timescale 1ns / 1ps
module prm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  prm_pkg::stat_t stat,
	output prm_pkg::cmd_t  cmd
);

	prm_pkg::state_t state_q;
	prm_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= prm_pkg::ST_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			prm_pkg::ST_IDLE: begin
				if (s_tvalid)
					state_nx = prm_pkg::ST_EVAL;
			end
			prm_pkg::ST_EVAL: begin
				state_nx = stat.is_sample ? prm_pkg::ST_MS : prm_pkg::ST_OUT;
			end
			prm_pkg::ST_MS: begin
				state_nx = prm_pkg::ST_EW;
			end
			prm_pkg::ST_EW: begin
				state_nx = prm_pkg::ST_MEAN;
			end
			prm_pkg::ST_MEAN: begin
				if (stat.div_done)
					state_nx = prm_pkg::ST_OUT;
			end
			prm_pkg::ST_OUT: begin
				if (stat.out_free)
					state_nx = prm_pkg::ST_IDLE;
			end
			default: state_nx = prm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			prm_pkg::ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
			end
			prm_pkg::ST_EVAL: begin
				cmd.eval = 1'b1;
			end
			prm_pkg::ST_MS: begin
				cmd.upd_ms    = 1'b1;
				cmd.div_start = 1'b1;
			end
			prm_pkg::ST_EW: begin
				cmd.upd_ewma = 1'b1;
			end
			prm_pkg::ST_MEAN: begin
				cmd.upd_mean = stat.div_done;
			end
			prm_pkg::ST_OUT: begin
				cmd.out_load = stat.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== hdl/prm_dp.sv =====
`timescale 1ns / 1ps
module prm_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [prm_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                             s_tuser,
	output logic [prm_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic [prm_pkg::KIND_W-1:0]       m_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic                             cfg_valid,
	input  logic [prm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [7:0]                       cfg_data,
	input  prm_pkg::cmd_t                    cmd,
	output prm_pkg::stat_t                   stat
);

	logic [7:0]  own_sys_q, own_comp_q;

	logic        op_q;
	logic [31:0] now_q;
	logic [63:0] itime_q;
	logic [31:0] iseq_q;
	logic [7:0]  tsys_q, tcomp_q, ssys_q, scomp_q;

	logic [15:0] probe_cnt_q;
	logic [31:0] out_seq_q;
	logic [31:0] sent_time_q;
	logic        awaiting_q;
	logic [31:0] count_q;
	logic [63:0] sum_q;
	logic [31:0] smooth_q;
	logic [31:0] least_q;
	logic [22:0] greatest_q;
	logic [31:0] timeouts_q;
	logic [7:0]  resp_q;
	logic [31:0] mean_q;

	logic [prm_pkg::KIND_W-1:0] kind_q;
	logic [63:0] otime_q;
	logic [31:0] oseq_q;
	logic [7:0]  otsys_q, otcomp_q;
	logic [31:0] rtt_q;

	logic [prm_pkg::OUT_DATA_W-1:0] mdata_q;
	logic [prm_pkg::KIND_W-1:0]     muser_q;
	logic                           mvalid_q;

	logic        ew_up_s1;
	logic [31:0] ew_old_s1;
	logic [31:0] ew_dist_s1;

	logic        bcast, to_us, match, is_sample;
	logic [31:0] rtt;
	logic [31:0] probe_seq;
	logic [63:0] ms_prod;
	logic [31:0] ms;
	logic [31:0] ew_old;
	logic        ew_up;
	logic [31:0] ew_dist;
	logic [63:0] ew_prod;
	logic [31:0] ew_f;
	logic [63:0] quo;
	logic        div_done;

	assign bcast = (tsys_q == 8'd0) && (tcomp_q == 8'd0);
	assign to_us = (tsys_q == own_sys_q || tsys_q == 8'd0)
		&& (tcomp_q == own_comp_q || tcomp_q == 8'd0);
	assign match = ((iseq_q & prm_pkg::SEQ_HIGH_MASK) == prm_pkg::SEQ_MAGIC)
		&& awaiting_q && (iseq_q == out_seq_q);
	assign is_sample = (op_q != prm_pkg::OP_TICK) && !bcast && to_us && match
		&& (resp_q == 8'd0 || ssys_q == resp_q);
	assign rtt       = now_q - sent_time_q;
	assign probe_seq = prm_pkg::SEQ_MAGIC | {16'd0, probe_cnt_q};

	assign ms_prod = {32'd0, rtt_q} * {32'd0, prm_pkg::MS_RECIP};
	assign ms      = {6'd0, ms_prod[63:38]};

	// (4*old + new) / 5 = old + (new - old) / 5, rounded toward minus infinity
	assign ew_old  = (smooth_q == 32'd0) ? rtt_q : smooth_q;
	assign ew_up   = rtt_q >= ew_old;
	assign ew_dist = ew_up ? (rtt_q - ew_old) : (ew_old - rtt_q - 32'd1);
	assign ew_prod = {32'd0, ew_dist_s1} * {32'd0, prm_pkg::EW_RECIP};
	assign ew_f    = {2'd0, ew_prod[63:34]};

	prm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.nbits    (prm_pkg::DIV_STEPS),
		.divisor  (count_q),
		.quo      (quo),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_sys_q   <= prm_pkg::ID_RESET;
			own_comp_q  <= prm_pkg::ID_RESET;
			probe_cnt_q <= '0;
			out_seq_q   <= '0;
			sent_time_q <= '0;
			awaiting_q  <= 1'b0;
			count_q     <= '0;
			sum_q       <= '0;
			smooth_q    <= '0;
			least_q     <= '1;
			greatest_q  <= '0;
			timeouts_q  <= '0;
			resp_q      <= '0;
			mean_q      <= '0;
			mvalid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_index == prm_pkg::REG_OWN_SYSTEM)
				own_sys_q <= cfg_data;
			if (cfg_valid && cfg_index == prm_pkg::REG_OWN_COMPONENT)
				own_comp_q <= cfg_data;
			if (cmd.eval) begin
				if (op_q == prm_pkg::OP_TICK) begin
					if (awaiting_q)
						timeouts_q <= timeouts_q + 32'd1;
					probe_cnt_q <= probe_cnt_q + 16'd1;
					out_seq_q   <= probe_seq;
					sent_time_q <= now_q;
					awaiting_q  <= 1'b1;
				end else if (!bcast && to_us && match) begin
					if (resp_q == 8'd0)
						resp_q <= ssys_q;
					if (is_sample) begin
						awaiting_q <= 1'b0;
						count_q    <= count_q + 32'd1;
						sum_q      <= sum_q + {32'd0, rtt};
					end
				end
			end
			if (cmd.upd_ms) begin
				if (ms < least_q)
					least_q <= ms;
				if (ms[22:0] > greatest_q)
					greatest_q <= ms[22:0];
			end
			if (cmd.upd_ewma)
				smooth_q <= ew_up_s1 ? (ew_old_s1 + ew_f) : (ew_old_s1 - ew_f - 32'd1);
			if (cmd.upd_mean)
				mean_q <= (count_q == 32'd0) ? 32'd0 : quo[31:0];
			if (cmd.out_load)
				mvalid_q <= 1'b1;
			else if (m_tready)
				mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q    <= s_tuser;
			now_q   <= s_tdata[31:0];
			itime_q <= s_tdata[95:32];
			iseq_q  <= s_tdata[127:96];
			tsys_q  <= s_tdata[135:128];
			tcomp_q <= s_tdata[143:136];
			ssys_q  <= s_tdata[151:144];
			scomp_q <= s_tdata[159:152];
		end
		if (cmd.upd_ms) begin
			ew_up_s1   <= ew_up;
			ew_old_s1  <= ew_old;
			ew_dist_s1 <= ew_dist;
		end
		if (cmd.eval) begin
			otime_q  <= '0;
			oseq_q   <= '0;
			otsys_q  <= '0;
			otcomp_q <= '0;
			rtt_q    <= '0;
			if (op_q == prm_pkg::OP_TICK) begin
				kind_q  <= prm_pkg::KIND_PROBE;
				otime_q <= {32'd0, now_q};
				oseq_q  <= probe_seq;
			end else if (bcast) begin
				kind_q   <= prm_pkg::KIND_ECHO;
				otime_q  <= itime_q;
				oseq_q   <= iseq_q;
				otsys_q  <= ssys_q;
				otcomp_q <= scomp_q;
			end else if (is_sample) begin
				kind_q <= prm_pkg::KIND_SAMPLE;
				rtt_q  <= rtt;
			end else begin
				kind_q <= prm_pkg::KIND_IGNORED;
			end
		end
		if (cmd.out_load) begin
			muser_q <= kind_q;
			mdata_q <= {2'b00, timeouts_q, mean_q, greatest_q, least_q,
				smooth_q[31:1], smooth_q, rtt_q, otcomp_q, otsys_q, oseq_q, otime_q};
		end
	end

	assign stat.is_sample = is_sample;
	assign stat.div_done  = div_done;
	assign stat.out_free  = !mvalid_q || m_tready;

	assign m_tdata  = mdata_q;
	assign m_tuser  = muser_q;
	assign m_tvalid = mvalid_q;

endmodule
